[hdl/tss_pkg.sv]
// Shared types, constants and microcode for the Taylor series sine core.
package tss_pkg;

    // Field widths
    localparam int ANGLE_W = 19;   // signed Q3.16 input
    localparam int SINE_W  = 21;   // signed Q5.16 output
    localparam int TC_W    = 4;    // term count register
    localparam int AX_W    = 19;   // |angle|, unsigned Q3.16
    localparam int X2_W    = 21;   // x^2, unsigned Q5.16
    localparam int M_W     = 20;   // term magnitude, unsigned Q16
    localparam int P_W     = 24;   // m*x2 product, unsigned Q16
    localparam int RC_W    = 22;   // reciprocal, unsigned Q0.24
    localparam int OPA_W   = 24;   // multiplier operand A
    localparam int OPB_W   = 22;   // multiplier operand B
    localparam int PROD_W  = OPA_W + OPB_W;
    localparam int SUM_W   = 23;   // running sum, signed
    localparam int PC_W    = 3;
    localparam int RECIP_LEN = 11;

    localparam logic [TC_W-1:0] TC_RESET = 4'd8;

    // Output range
    localparam logic signed [SUM_W-1:0] SUM_MAX = 23'sd1048575;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -23'sd1048576;

    // Rounding constants for the >>16 and >>24 products
    localparam logic [PROD_W-1:0] RND_16 = 46'h0000_0000_8000;
    localparam logic [PROD_W-1:0] RND_24 = 46'h0000_0080_0000;

    // Operand A select
    localparam logic [1:0] A_AX = 2'd0;
    localparam logic [1:0] A_P  = 2'd1;
    localparam logic [1:0] A_M  = 2'd2;

    // Operand B select
    localparam logic [1:0] B_AX  = 2'd0;
    localparam logic [1:0] B_PX2 = 2'd1;
    localparam logic [1:0] B_X2  = 2'd2;
    localparam logic [1:0] B_RC  = 2'd3;

    // Branch codes
    localparam logic [1:0] BR_NEXT = 2'd0;
    localparam logic [1:0] BR_N1   = 2'd1;  // to finish when only one term
    localparam logic [1:0] BR_LOOP = 2'd2;  // to finish on last term, else to target
    localparam logic [1:0] BR_END  = 2'd3;

    // Program steps
    localparam logic [PC_W-1:0] PC_SQ  = 3'd0;
    localparam logic [PC_W-1:0] PC_X2  = 3'd1;
    localparam logic [PC_W-1:0] PC_MR  = 3'd2;
    localparam logic [PC_W-1:0] PC_MP  = 3'd3;
    localparam logic [PC_W-1:0] PC_FIN = 3'd4;

    typedef struct packed {
        logic [1:0]      a_sel;
        logic [1:0]      b_sel;
        logic            rnd_hi;
        logic            ld_x2;
        logic            acc;
        logic [1:0]      br;
        logic [PC_W-1:0] target;
    } t_uword;

    // Control store
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{a_sel: A_AX, b_sel: B_AX, rnd_hi: 1'b0, ld_x2: 1'b0, acc: 1'b0,
              br: BR_END, target: PC_FIN};
        case (pc)
            // square the magnitude
            PC_SQ: begin
                w.br = BR_NEXT;
            end
            // latch x2, first m*x2 with m = |x|
            PC_X2: begin
                w.b_sel = B_PX2;
                w.ld_x2 = 1'b1;
                w.br    = BR_N1;
            end
            // p times reciprocal
            PC_MR: begin
                w.a_sel  = A_P;
                w.b_sel  = B_RC;
                w.rnd_hi = 1'b1;
                w.br     = BR_NEXT;
            end
            // take new term, accumulate, next m*x2
            PC_MP: begin
                w.a_sel  = A_M;
                w.b_sel  = B_X2;
                w.acc    = 1'b1;
                w.br     = BR_LOOP;
                w.target = PC_MR;
            end
            default: begin
                w.br = BR_END;
            end
        endcase
        return w;
    endfunction

    // 1/(k(k-1)) for k = 3, 5, ..., 23 in unsigned Q0.24, rounded
    function automatic logic [RC_W-1:0] recip(input logic [TC_W-1:0] idx);
        logic [RC_W-1:0] r;
        case (idx)
            4'd0:    r = 22'd2796203;
            4'd1:    r = 22'd838861;
            4'd2:    r = 22'd399458;
            4'd3:    r = 22'd233017;
            4'd4:    r = 22'd152520;
            4'd5:    r = 22'd107546;
            4'd6:    r = 22'd79892;
            4'd7:    r = 22'd61681;
            4'd8:    r = 22'd49056;
            4'd9:    r = 22'd39946;
            4'd10:   r = 22'd33157;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[hdl/taylor_sine_series_core.sv]
// Top level: microcoded fixed-point Taylor series sine on one shared multiplier.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-----------------------------------
//  command  | start / busy                | i_angle (s Q3.16)
//  result   | o_done strobe, one cycle    | o_sine_value (s Q5.16), o_saturated
//  config   | i_cfg_valid / o_cfg_ready   | i_cfg_data (term count)
//
// An item squares |x|, latches x2 with the first m*x2, then for each further
// term multiplies by a reciprocal and accumulates; two dependent multiplies per
// term share the one 24x22 multiplier. busy is high from the accept edge until
// the result cycle, in which a new command may already be taken. Reset (i_rst_n
// low at a clock edge) drops any item in flight and restores the term count to
// eight. o_done flags each new result, which the outputs hold until the next.
module taylor_sine_series_core #(
    parameter int MAX_TERMS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [tss_pkg::ANGLE_W-1:0]  i_angle,
    output logic                                o_done,
    output logic signed [tss_pkg::SINE_W-1:0]   o_sine_value,
    output logic                                o_saturated,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tss_pkg::TC_W-1:0]            i_cfg_data
);

    localparam logic [tss_pkg::TC_W-1:0] MaxTc = tss_pkg::TC_W'(MAX_TERMS);

    // Registers
    logic                              r_busy;
    logic [tss_pkg::PC_W-1:0]          r_pc,   n_pc;
    logic [tss_pkg::TC_W-1:0]          r_tc;
    logic [tss_pkg::TC_W-1:0]          r_last;
    logic [tss_pkg::TC_W-1:0]          r_term, n_term;
    logic                              r_neg;
    logic [tss_pkg::AX_W-1:0]          r_ax;
    logic [tss_pkg::X2_W-1:0]          r_x2;
    logic [tss_pkg::PROD_W-1:0]        r_prod, n_prod;
    logic signed [tss_pkg::SUM_W-1:0]  r_sum,  n_sum;
    logic                              r_done;
    logic signed [tss_pkg::SINE_W-1:0] r_sine, n_sine;
    logic                              r_sat,  n_sat;

    // Combinational
    tss_pkg::t_uword                   uw;
    logic                              accept;
    logic [tss_pkg::AX_W-1:0]          in_ax;
    logic [tss_pkg::TC_W-1:0]          n_eff;
    logic [tss_pkg::OPA_W-1:0]         op_a;
    logic [tss_pkg::OPB_W-1:0]         op_b;
    logic [tss_pkg::M_W-1:0]           term_m;
    logic signed [tss_pkg::SUM_W-1:0]  fin_sum;
    logic                              is_fin;

    assign accept      = start && !r_busy;
    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_sine_value = r_sine;
    assign o_saturated = r_sat;

    assign uw     = tss_pkg::ucode(r_pc);
    assign is_fin = (r_pc == tss_pkg::PC_FIN);

    // Magnitude of the incoming angle
    assign in_ax = i_angle[tss_pkg::ANGLE_W-1] ? (~i_angle + 19'd1) : i_angle;

    // Clamp term count to 1..MAX_TERMS
    always_comb begin
        if (r_tc == '0) begin
            n_eff = tss_pkg::TC_W'(1);
        end else if (r_tc > MaxTc) begin
            n_eff = MaxTc;
        end else begin
            n_eff = r_tc;
        end
    end

    // Operand selection and shared multiply with rounding constant
    assign term_m = r_prod[43:24];

    always_comb begin
        case (uw.a_sel)
            tss_pkg::A_AX: op_a = tss_pkg::OPA_W'(r_ax);
            tss_pkg::A_P:  op_a = r_prod[39:16];
            tss_pkg::A_M:  op_a = tss_pkg::OPA_W'(term_m);
            default:       op_a = '0;
        endcase
        case (uw.b_sel)
            tss_pkg::B_AX:  op_b = tss_pkg::OPB_W'(r_ax);
            tss_pkg::B_PX2: op_b = tss_pkg::OPB_W'(r_prod[36:16]);
            tss_pkg::B_X2:  op_b = tss_pkg::OPB_W'(r_x2);
            tss_pkg::B_RC:  op_b = tss_pkg::recip(r_term - tss_pkg::TC_W'(1));
            default:        op_b = '0;
        endcase
        n_prod = tss_pkg::PROD_W'(op_a) * tss_pkg::PROD_W'(op_b)
               + (uw.rnd_hi ? tss_pkg::RND_24 : tss_pkg::RND_16);
    end

    // Accumulate alternating terms; odd terms subtract
    always_comb begin
        n_sum = r_sum;
        if (uw.acc) begin
            if (r_term[0]) begin
                n_sum = r_sum - tss_pkg::SUM_W'(term_m);
            end else begin
                n_sum = r_sum + tss_pkg::SUM_W'(term_m);
            end
        end
    end

    // Sequencer: next step and term counter
    always_comb begin
        n_term = r_term;
        case (uw.br)
            tss_pkg::BR_NEXT: n_pc = r_pc + tss_pkg::PC_W'(1);
            tss_pkg::BR_N1: begin
                n_pc = (r_last == '0) ? tss_pkg::PC_FIN : r_pc + tss_pkg::PC_W'(1);
            end
            tss_pkg::BR_LOOP: begin
                if (r_term == r_last) begin
                    n_pc = tss_pkg::PC_FIN;
                end else begin
                    n_pc   = uw.target;
                    n_term = r_term + tss_pkg::TC_W'(1);
                end
            end
            default: n_pc = r_pc;
        endcase
    end

    // Apply sign and saturate
    always_comb begin
        fin_sum = r_neg ? -r_sum : r_sum;
        n_sat   = 1'b0;
        if (fin_sum > tss_pkg::SUM_MAX) begin
            n_sine = tss_pkg::SINE_W'(tss_pkg::SUM_MAX);
            n_sat  = 1'b1;
        end else if (fin_sum < tss_pkg::SUM_MIN) begin
            n_sine = tss_pkg::SINE_W'(tss_pkg::SUM_MIN);
            n_sat  = 1'b1;
        end else begin
            n_sine = tss_pkg::SINE_W'(fin_sum);
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_pc   <= tss_pkg::PC_SQ;
            r_tc   <= tss_pkg::TC_RESET;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tc <= i_cfg_data;
            end
            if (accept) begin
                r_busy <= 1'b1;
                r_pc   <= tss_pkg::PC_SQ;
            end else if (r_busy) begin
                if (is_fin) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_pc <= n_pc;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ax   <= in_ax;
            r_neg  <= i_angle[tss_pkg::ANGLE_W-1];
            r_sum  <= tss_pkg::SUM_W'(in_ax);
            r_term <= tss_pkg::TC_W'(1);
            r_last <= n_eff - tss_pkg::TC_W'(1);
        end else if (r_busy && !is_fin) begin
            r_prod <= n_prod;
            r_sum  <= n_sum;
            r_term <= n_term;
            if (uw.ld_x2) begin
                r_x2 <= r_prod[36:16];
            end
        end
        if (r_busy && is_fin) begin
            r_sine <= n_sine;
            r_sat  <= n_sat;
        end
    end

endmodule

[hdl/tss_checker.sv]
// Port-level checker for the Taylor series sine core, with its bind.
module tss_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               o_done,
    input logic signed [tss_pkg::SINE_W-1:0]  o_sine_value,
    input logic                               o_saturated
);

    // An accepted command makes the core busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // Result strobe shows only once the core is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // Busy ends only with a result
    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_done)
        else $error("busy dropped without a result");

    // Result strobe never comes back to back
    a_single_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe repeated");

    // A clipped result sits at a range end
    a_sat_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_saturated) |->
        (o_sine_value == 21'sh0FFFFF || o_sine_value == 21'sh100000))
        else $error("saturated result not at range end");

endmodule

bind taylor_sine_series_core tss_checker u_tss_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_sine_value (o_sine_value),
    .o_saturated  (o_saturated)
);

[tb/tb_top.sv]
// Self-checking testbench for the Taylor series sine core: directed table, then random angles.
module tb_top;

    localparam int CORE_TERMS  = 8;
    localparam int TABLE_TERMS = tss_pkg::RECIP_LEN + 1;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 100;
    localparam int NUM_PHASES  = 10;
    localparam int TAIL_CYCLES = 40;

    // One expected sine transaction
    typedef struct {
        logic signed [tss_pkg::ANGLE_W-1:0] angle;
        logic [tss_pkg::TC_W-1:0]           terms;
        logic signed [tss_pkg::SINE_W-1:0]  value;
        logic                               sat;
    } t_sine_exp;

    // One row of the directed stimulus table
    typedef struct {
        logic [tss_pkg::TC_W-1:0]           terms;
        logic signed [tss_pkg::ANGLE_W-1:0] angle;
        bit                                 typed;
        logic signed [tss_pkg::SINE_W-1:0]  value;
        logic                               sat;
    } t_dir_row;

    localparam int DIR_ROWS = 19;
    t_dir_row dir_tab [DIR_ROWS] = '{
        // reset term count of eight
        '{4'd8,   19'sd0,        1'b1, 21'sd0,        1'b0},
        '{4'd8,   19'sd65536,    1'b0, 21'sd0,        1'b0},
        '{4'd8,  -19'sd65536,    1'b0, 21'sd0,        1'b0},
        '{4'd8,   19'sd102944,   1'b0, 21'sd0,        1'b0},
        '{4'd8,  -19'sd102944,   1'b0, 21'sd0,        1'b0},
        '{4'd8,   19'sd205887,   1'b0, 21'sd0,        1'b0},
        '{4'd8,   19'sd262143,   1'b0, 21'sd0,        1'b0},
        '{4'd8,  -19'sd262144,   1'b0, 21'sd0,        1'b0},
        // single term: result is the angle itself
        '{4'd1,   19'sd0,        1'b1, 21'sd0,        1'b0},
        '{4'd1,   19'sd1,        1'b1, 21'sd1,        1'b0},
        '{4'd1,  -19'sd1,        1'b1, -21'sd1,       1'b0},
        '{4'd1,   19'sd262143,   1'b1, 21'sd262143,   1'b0},
        '{4'd1,  -19'sd262144,   1'b1, -21'sd262144,  1'b0},
        // zero terms behaves as one term
        '{4'd0,   19'sd262143,   1'b1, 21'sd262143,   1'b0},
        '{4'd0,  -19'sd262144,   1'b1, -21'sd262144,  1'b0},
        // too many terms is clamped; then two terms
        '{4'd15,  19'sd262143,   1'b0, 21'sd0,        1'b0},
        '{4'd15, -19'sd262144,   1'b0, 21'sd0,        1'b0},
        '{4'd15,  19'sd65536,    1'b0, 21'sd0,        1'b0},
        '{4'd2,   19'sd262143,   1'b0, 21'sd0,        1'b0}
    };

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                start;
    logic                                busy;
    logic signed [tss_pkg::ANGLE_W-1:0]  i_angle;
    logic                                o_done;
    logic signed [tss_pkg::SINE_W-1:0]   o_sine_value;
    logic                                o_saturated;
    logic                                i_cfg_valid;
    logic                                o_cfg_ready;
    logic [tss_pkg::TC_W-1:0]            i_cfg_data;

    t_sine_exp                sine_q [$];
    t_sine_exp                got_exp;
    logic [tss_pkg::TC_W-1:0] cur_terms;
    int                       mismatches;
    int                       checked;
    int                       cfg_writes;
    int                       cycle_cnt;

    taylor_sine_series_core #(
        .MAX_TERMS (CORE_TERMS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_angle      (i_angle),
        .o_done       (o_done),
        .o_sine_value (o_sine_value),
        .o_saturated  (o_saturated),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Series sum on |x| with alternating terms, sign applied last, then clipped
    function automatic t_sine_exp series_sine(
            input logic signed [tss_pkg::ANGLE_W-1:0] ang,
            input logic [tss_pkg::TC_W-1:0] terms);
        t_sine_exp  r;
        logic [tss_pkg::ANGLE_W-1:0] raw;
        bit         neg;
        longint     ax;
        longint     x2;
        longint     m;
        longint     p;
        longint     d;
        longint     rc;
        longint     sum;
        int         n;
        raw = ang;
        neg = raw[tss_pkg::ANGLE_W-1];
        ax  = neg ? ((longint'(1) << tss_pkg::ANGLE_W) - longint'(raw)) : longint'(raw);
        x2  = (ax * ax + 64'h8000) >>> 16;
        n   = terms;
        if (n < 1) n = 1;
        if (n > CORE_TERMS) n = CORE_TERMS;
        if (n > TABLE_TERMS) n = TABLE_TERMS;
        m   = ax;
        sum = ax;
        for (int i = 1; i < n; i++) begin
            d  = longint'(2 * i + 1) * longint'(2 * i);
            rc = ((longint'(1) << 24) + d / 2) / d;
            p  = (m * x2 + 64'h8000) >>> 16;
            m  = (p * rc + 64'h80_0000) >>> 24;
            if (i % 2 == 1) sum = sum - m;
            else            sum = sum + m;
        end
        if (neg) sum = -sum;
        r.sat = 1'b0;
        if (sum > 1048575) begin
            sum   = 1048575;
            r.sat = 1'b1;
        end else if (sum < -1048576) begin
            sum   = -1048576;
            r.sat = 1'b1;
        end
        r.angle = ang;
        r.terms = terms;
        r.value = sum[tss_pkg::SINE_W-1:0];
        return r;
    endfunction

    // Issue one angle after a random idle stretch; record the expectation at accept
    task automatic send_angle(input logic signed [tss_pkg::ANGLE_W-1:0] ang,
                              input int idle_pct, input bit typed,
                              input logic signed [tss_pkg::SINE_W-1:0] tv,
                              input logic ts);
        t_sine_exp e;
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start   <= 1'b1;
        i_angle <= ang;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        e = series_sine(ang, cur_terms);
        if (typed) begin
            e.value = tv;
            e.sat   = ts;
        end
        sine_q.push_back(e);
    endtask

    // Drop start and hold until every expected result has come back
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (sine_q.size() != 0) @(negedge i_clk);
    endtask

    // Write the term count register while the core is idle
    task automatic write_terms(input logic [tss_pkg::TC_W-1:0] terms);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= terms;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cur_terms = terms;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Pick an angle: mostly uniform, some near zero, some near the range ends
    function automatic logic signed [tss_pkg::ANGLE_W-1:0] pick_angle();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) return 19'($urandom());
        if (sel < 82) return $signed(19'($urandom_range(511))) - 19'sd256;
        if (sel < 91) return 19'($urandom_range(262143, 262143 - 1023));
        if (sel < 98) return 19'(-262144 + int'($urandom_range(1023)));
        case ($urandom_range(2))
            0:       return 19'sd0;
            1:       return 19'sd262143;
            default: return -19'sd262144;
        endcase
    endfunction

    // Compare each result strobe against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (sine_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: sine %0d sat %0b", o_sine_value, o_saturated);
                mismatches++;
            end else begin
                got_exp = sine_q.pop_front();
                checked++;
                if (o_sine_value !== got_exp.value || o_saturated !== got_exp.sat) begin
                    if (mismatches < 10)
                        $display("sine error: angle %0d terms %0d exp %0d/%0b got %0d/%0b",
                                 got_exp.angle, got_exp.terms, got_exp.value, got_exp.sat,
                                 o_sine_value, o_saturated);
                    mismatches++;
                end
            end
        end
    end

    // Cycle limit
    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_cnt);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        logic [tss_pkg::TC_W-1:0] phase_terms [NUM_PHASES];
        int                       phase_idle  [3];
        phase_terms = '{4'd15, 4'd1, 4'd8, 4'd0, 4'd3, 4'd12, 4'd5, 4'd2, 4'd7, 4'd6};
        phase_idle  = '{0, 84, 15};
        mismatches  = 0;
        checked     = 0;
        cfg_writes  = 0;
        cur_terms   = tss_pkg::TC_RESET;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_angle     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // walk the directed table, rewriting the term count where it changes
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_tab[r].terms != cur_terms) write_terms(dir_tab[r].terms);
            send_angle(dir_tab[r].angle, 15, dir_tab[r].typed, dir_tab[r].value,
                       dir_tab[r].sat);
        end

        // random phases, each with its own term count and one of three idle rates
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_terms(phase_terms[ph]);
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_angle(pick_angle(), phase_idle[ph % 3], 1'b0, '0, 1'b0);
        end
        // one more phase at a random count
        write_terms(4'($urandom_range(15)));
        for (int k = 0; k < PHASE_ITEMS / 2; k++)
            send_angle(pick_angle(), phase_idle[k % 3], 1'b0, '0, 1'b0);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sine_q.size() != 0) mismatches++;

        $display("Summary: %0d sine results checked across %0d term count writes,",
                 checked, cfg_writes);
        $display("covering zero, mid and clamped term counts, full-scale angles, "
                 , "and commands issued both as soon as the core frees up and after idling.");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d errors", mismatches);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
